// ===== design/rcfp_pkg.sv =====
`default_nettype none

package rcfp_pkg;

    // Frame position codes: 0 is the power byte, 1..6 are the hex digits.
    localparam logic [2:0] POS_POWER   = 3'd0;
    localparam logic [2:0] POS_DIGIT1  = 3'd1;
    localparam logic [2:0] POS_DIGIT6  = 3'd6;
    localparam logic [2:0] POS_HUNTING = 3'd7;

    // Sync word characters, "START".
    localparam logic [7:0] CHAR_S = 8'h53;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_R = 8'h52;

    // Power command characters.
    localparam logic [7:0] CHAR_POWER_OFF = 8'h30;
    localparam logic [7:0] CHAR_POWER_ON  = 8'h31;

    localparam logic [23:0] COLOR_RESET = 24'hBB0E13;

    // One input beat.
    typedef struct packed {
        logic [7:0] rx_byte;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic       power_on;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       color_updated;
        logic       sync_seen;
    } t_out_beat;

    // Hex digit value of an ASCII byte, either case; anything else reads as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h61 + 8'd10);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/rcfp_stream_if.sv =====
`default_nettype none

// Valid/ready channel that carries one payload per beat.
interface rcfp_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/rgb_command_frame_parser_core.sv =====
`default_nettype none

// RGB command frame parser. Takes one received UART byte per beat and returns
// one result beat per byte: the power flag and colour as they stand after that
// byte, plus strobes for a completed "START" sync word and for a completed
// frame that loaded a nonzero colour. A frame is the sync word, a power byte
// ('0' off, '1' on, anything else no change) and six hex digits, most
// significant first. A new byte is taken every cycle while the result register
// can take it: the parser state updates in a single pass and the result sits in an
// output register that stays open to a new byte whenever it is empty or is
// being taken in the same cycle. The result beat is presented in the cycle after
// its byte is accepted. After reset the colour is 0xBB0E13 and power is on.
module rgb_command_frame_parser_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    rcfp_stream_if.sink   i_rx,
    rcfp_stream_if.source o_res
);
    import rcfp_pkg::*;

    logic      accept;
    t_out_beat step_result;
    t_out_beat r_out;
    logic      r_out_valid;

    // Accept a byte when the result register is free or is being emptied.
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;

    rcfp_frame_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (accept),
        .i_byte   (i_rx.payload.rx_byte),
        .o_result (step_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= step_result;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // A byte cannot both finish the sync word and finish a frame.
    a_strobes_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.color_updated && r_out.sync_seen))
        else $error("sync and colour strobes set on the same result");

    // A loaded colour is never zero.
    a_update_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.color_updated) |->
            (r_out.red != 8'd0 || r_out.green != 8'd0 || r_out.blue != 8'd0))
        else $error("colour update carries a zero colour");

    // Every accepted byte leaves a result in the output register.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted byte left no result");

endmodule

`default_nettype wire

// ===== design/rcfp_frame_core.sv =====
`default_nettype none

// Parser state and the per-byte update. The result for a byte is the state
// after that byte has been handled; it is presented combinationally and the
// state advances at the edge where i_take is high.
module rcfp_frame_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_take,
    input  wire logic [7:0]          i_byte,
    output      rcfp_pkg::t_out_beat o_result
);
    import rcfp_pkg::*;

    logic [7:0]  r_window [4];
    logic [2:0]  r_pos;
    logic [23:0] r_acc;
    logic        r_power;
    logic [23:0] r_color;

    logic [7:0]  n_window [4];
    logic [2:0]  n_pos;
    logic [23:0] n_acc;
    logic        n_power;
    logic [23:0] n_color;
    logic        n_updated;
    logic        n_synced;
    logic [23:0] acc_shift;

    assign acc_shift = {r_acc[19:0], hex_value(i_byte)};

    // Next state for the byte on i_byte.
    always_comb begin
        n_window  = r_window;
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_power   = r_power;
        n_color   = r_color;
        n_updated = 1'b0;
        n_synced  = 1'b0;
        if (r_pos == POS_HUNTING) begin
            n_window[0] = r_window[1];
            n_window[1] = r_window[2];
            n_window[2] = r_window[3];
            n_window[3] = i_byte;
            if (r_window[0] == CHAR_S && r_window[1] == CHAR_T &&
                r_window[2] == CHAR_A && r_window[3] == CHAR_R && i_byte == CHAR_T) begin
                n_synced = 1'b1;
                n_pos    = POS_POWER;
                n_acc    = '0;
            end
        end else if (r_pos == POS_POWER) begin
            if (i_byte == CHAR_POWER_OFF) begin
                n_power = 1'b0;
            end else if (i_byte == CHAR_POWER_ON) begin
                n_power = 1'b1;
            end
            n_pos = POS_DIGIT1;
        end else begin
            n_acc = acc_shift;
            n_pos = r_pos + 3'd1;
            if (r_pos == POS_DIGIT6 && acc_shift != '0) begin
                n_color   = acc_shift;
                n_acc     = '0;
                n_updated = 1'b1;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_window[k] <= '0;
            end
            r_pos   <= POS_HUNTING;
            r_acc   <= '0;
            r_power <= 1'b1;
            r_color <= COLOR_RESET;
        end else if (i_take) begin
            r_window <= n_window;
            r_pos    <= n_pos;
            r_acc    <= n_acc;
            r_power  <= n_power;
            r_color  <= n_color;
        end
    end

    assign o_result.power_on      = n_power;
    assign o_result.red           = n_color[23:16];
    assign o_result.green         = n_color[15:8];
    assign o_result.blue          = n_color[7:0];
    assign o_result.color_updated = n_updated;
    assign o_result.sync_seen     = n_synced;

endmodule

`default_nettype wire

// ===== bench/rcfp_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the frame parser. Each accepted input beat is run
// through a cycle-free model of the parser, and the result it should produce is
// queued. Each accepted result beat is compared, field by field, with the oldest
// queued result.
module rcfp_checker
    import rcfp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_rx_valid,
    input  wire logic i_rx_ready,
    input  t_in_beat  i_rx_payload,
    input  wire logic i_res_valid,
    input  wire logic i_res_ready,
    input  t_out_beat i_res_payload,
    output int        o_fail_count,
    output int        o_outstanding
);

    // Model of the parser state.
    logic [7:0]  sync_hist [4];
    logic [2:0]  frame_pos;
    logic [23:0] hex_acc;
    logic        power_now;
    logic [23:0] color_now;

    t_out_beat   expected_results [$];
    int          fails = 0;

    // ASCII hex digit to its value; anything that is not a hex digit reads as zero.
    function automatic logic [3:0] digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return c[3:0];
        end
        // 'A'..'F' and 'a'..'f' have low nibbles 1..6.
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            return c[3:0] + 4'd9;
        end
        return 4'd0;
    endfunction

    // Advance the parser model by one received byte and queue the result.
    task automatic predict_byte(input logic [7:0] b);
        t_out_beat want;
        logic      hit;
        want = '0;
        if (frame_pos == POS_HUNTING) begin
            hit = sync_hist[0] == CHAR_S && sync_hist[1] == CHAR_T &&
                  sync_hist[2] == CHAR_A && sync_hist[3] == CHAR_R && b == CHAR_T;
            sync_hist[0] = sync_hist[1];
            sync_hist[1] = sync_hist[2];
            sync_hist[2] = sync_hist[3];
            sync_hist[3] = b;
            if (hit) begin
                want.sync_seen = 1'b1;
                frame_pos = POS_POWER;
                hex_acc = '0;
            end
        end else if (frame_pos == POS_POWER) begin
            if (b == CHAR_POWER_OFF) begin
                power_now = 1'b0;
            end else if (b == CHAR_POWER_ON) begin
                power_now = 1'b1;
            end
            frame_pos = POS_DIGIT1;
        end else begin
            hex_acc = {hex_acc[19:0], digit_of(b)};
            if (frame_pos == POS_DIGIT6) begin
                // A frame of all-zero digits keeps the old colour.
                if (hex_acc != '0) begin
                    color_now = hex_acc;
                    hex_acc = '0;
                    want.color_updated = 1'b1;
                end
                frame_pos = POS_HUNTING;
            end else begin
                frame_pos = frame_pos + 3'd1;
            end
        end
        want.power_on = power_now;
        want.red = color_now[23:16];
        want.green = color_now[15:8];
        want.blue = color_now[7:0];
        expected_results.push_back(want);
    endtask

    task automatic check_field(input string field_name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", field_name, want, got);
            fails++;
        end
    endtask

    task automatic compare_result(input t_out_beat got);
        t_out_beat want;
        if (expected_results.size() == 0) begin
            $error("result beat arrived with no result pending");
            fails++;
        end else begin
            want = expected_results.pop_front();
            check_field("power_on", 8'(want.power_on), 8'(got.power_on));
            check_field("red", want.red, got.red);
            check_field("green", want.green, got.green);
            check_field("blue", want.blue, got.blue);
            check_field("color_updated", 8'(want.color_updated), 8'(got.color_updated));
            check_field("sync_seen", 8'(want.sync_seen), 8'(got.sync_seen));
        end
    endtask

    // Results are taken before new bytes so that a result in the same cycle as its byte is caught.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (sync_hist[k]) begin
                sync_hist[k] = '0;
            end
            frame_pos = POS_HUNTING;
            hex_acc = '0;
            power_now = 1'b1;
            color_now = COLOR_RESET;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                compare_result(i_res_payload);
            end
            if (i_rx_valid && i_rx_ready) begin
                predict_byte(i_rx_payload.rx_byte);
            end
        end
        o_fail_count <= fails;
        o_outstanding <= expected_results.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import rcfp_pkg::*;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_LIGHT
    } t_stall_mode;

    localparam int DIRECTED_BYTES = 25;
    localparam int RANDOM_BYTES   = 1650;
    localparam int DRAIN_EVERY    = 300;
    localparam int TAIL_CYCLES    = 8;

    localparam logic [7:0] ASCII_ZERO = "0";
    localparam logic [7:0] NOT_HEX    = "z";

    localparam logic [7:0] SYNC_WORD [5] = '{CHAR_S, CHAR_T, CHAR_A, CHAR_R, CHAR_T};

    // A zero byte, a frame with mixed-case and non-hex digits that turns power
    // off, then a frame with an unknown power byte and all-zero digits.
    localparam logic [7:0] DIRECTED [DIRECTED_BYTES] = '{
        8'h00,
        CHAR_S, CHAR_T, CHAR_A, CHAR_R, CHAR_T, CHAR_POWER_OFF,
        "f", "F", "9", "a", "G", "0",
        CHAR_S, CHAR_T, CHAR_A, CHAR_R, CHAR_T, 8'hFF,
        "0", "x", "0", "0", "0", "0"
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   outstanding;
    int   sent_bytes = 0;
    int   burst_left = 0;

    rcfp_stream_if #(.t_payload(t_in_beat))  rx_if ();
    rcfp_stream_if #(.t_payload(t_out_beat)) res_if ();

    rgb_command_frame_parser_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_if),
        .o_res  (res_if)
    );

    rcfp_checker frame_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (rx_if.valid),
        .i_rx_ready   (rx_if.ready),
        .i_rx_payload (rx_if.payload),
        .i_res_valid  (res_if.valid),
        .i_res_ready  (res_if.ready),
        .i_res_payload(res_if.payload),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the parser hangs.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: ready follows a stall mode that is picked again at random whenever its run ends.
    initial begin
        t_stall_mode stall_mode;
        int          stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            case (stall_mode)
                STALL_NONE: begin
                    res_if.ready <= 1'b1;
                end
                STALL_COIN: begin
                    res_if.ready <= 1'($urandom_range(0, 1));
                end
                STALL_HEAVY: begin
                    res_if.ready <= ($urandom_range(0, 7) == 0);
                end
                default: begin
                    res_if.ready <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    // Send one beat. Bursts of random length are separated by random gaps.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        rx_if.valid <= 1'b1;
        rx_if.payload.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) begin
            @(posedge i_clk);
        end
        burst_left--;
        sent_bytes++;
    endtask

    // Hold off the sender until every pending result has come back.
    task automatic drain_results;
        rx_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_sync_prefix(input int n);
        for (int k = 0; k < n; k++) begin
            send_byte(SYNC_WORD[k]);
        end
    endtask

    function automatic logic [7:0] random_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return ASCII_ZERO + 8'(v);
        end
        return ($urandom_range(0, 1) ? "a" : "A") + 8'(v - 10);
    endfunction

    // A whole frame with random content. With sync_in_digits set, the digit
    // slots carry the sync word, which the parser must not react to.
    task automatic send_frame(input bit sync_in_digits);
        int         pick;
        bit         zero_frame;
        logic [7:0] b;
        send_sync_prefix(5);
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            send_byte(CHAR_POWER_OFF);
        end else if (pick < 8) begin
            send_byte(CHAR_POWER_ON);
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
        zero_frame = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < 6; k++) begin
            if (sync_in_digits && k < 5) begin
                b = SYNC_WORD[k];
            end else if (zero_frame) begin
                b = ($urandom_range(0, 3) == 0) ? NOT_HEX : ASCII_ZERO;
            end else if ($urandom_range(0, 7) == 0) begin
                b = 8'($urandom_range(0, 255));
            end else begin
                b = random_hex_char();
            end
            send_byte(b);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int pick;
        int next_drain;
        rx_if.valid <= 1'b0;
        rx_if.payload <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) begin
            send_byte(DIRECTED[k]);
        end
        drain_results();

        // Mostly well-formed frames, with broken sync words and noise mixed in.
        next_drain = sent_bytes + DRAIN_EVERY;
        while (sent_bytes < DIRECTED_BYTES + RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_frame(1'b0);
            end else if (pick < 70) begin
                send_frame(1'b1);
            end else if (pick < 85) begin
                send_sync_prefix($urandom_range(1, 4));
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_byte(8'($urandom_range(0, 255)));
                end
            end
            if (sent_bytes >= next_drain) begin
                drain_results();
                next_drain = sent_bytes + DRAIN_EVERY;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/rcfp_pkg.sv
design/rcfp_stream_if.sv
design/rcfp_frame_core.sv
design/rgb_command_frame_parser_core.sv
bench/rcfp_checker.sv
bench/tb.sv
